FILE: src/cubic_bezier_sampler_core_assert.svh
// Assertion macros, clocked on clock, disabled in reset.
`ifndef CUBIC_BEZIER_SAMPLER_CORE_ASSERT_SVH
`define CUBIC_BEZIER_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication
`define CBS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cbs assertion failed");

// next-cycle implication
`define CBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cbs assertion failed");

`endif

FILE: src/cbs_pkg.sv
package cbs_pkg;

   localparam int COORD_BITS_DEFAULT   = 12;
   localparam int MAX_SEG_LOG2_DEFAULT = 5;

   localparam int LG_W       = 3;
   localparam int IDX_W      = 6;
   localparam int TAN_W      = 15;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_LSB = 2;

   localparam logic [LG_W-1:0] SEG_LOG2_RESET = 3'd5;

   localparam logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] CSR_IDX_SEG_LOG2 = 1'b0;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IDX_W-1:0] index;
      logic [LG_W-1:0]  lg;
   } cbs_tag_type;

endpackage

FILE: src/cbs_datapath.sv
module cbs_datapath #(
   parameter int COORD_BITS   = cbs_pkg::COORD_BITS_DEFAULT,
   parameter int MAX_SEG_LOG2 = cbs_pkg::MAX_SEG_LOG2_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cbs_pkg::cbs_tag_type               tag_i,
   input  logic signed [COORD_BITS-1:0]       px_i [4],
   input  logic signed [COORD_BITS-1:0]       py_i [4],
   output cbs_pkg::cbs_tag_type               tag_o,
   output logic signed [COORD_BITS-1:0]       point_x_o,
   output logic signed [COORD_BITS-1:0]       point_y_o,
   output logic signed [cbs_pkg::TAN_W-1:0]   tan_x_o,
   output logic signed [cbs_pkg::TAN_W-1:0]   tan_y_o
);
   import cbs_pkg::*;

   localparam int J_W  = MAX_SEG_LOG2 + 1;
   localparam int SQ_W = 2 * J_W;
   localparam int CU_W = 3 * J_W;
   localparam int WW   = CU_W + 2;
   localparam int PW   = COORD_BITS + WW;
   localparam int SW   = PW + 2;
   localparam int K_W  = LG_W + 2;

   function automatic logic signed [WW-1:0] times3(input logic signed [WW-1:0] a);
      return a + (a <<< 1);
   endfunction

   function automatic logic signed [SW-1:0] trunc_shift(input logic signed [SW-1:0] s,
                                                        input logic [K_W-1:0] k);
      logic [SW-1:0]        bias;
      logic signed [SW-1:0] adj;
      bias = (SW'(1) << k) - SW'(1);
      adj  = s + (s[SW-1] ? signed'(bias) : '0);
      return adj >>> k;
   endfunction

   // stage 1: squares and cross term
   cbs_tag_type                 s1_tag_ff, s1_tag_in;
   logic [J_W-1:0]              s1_u_ff, s1_u_in, s1_j_ff, s1_j_in;
   logic [SQ_W-1:0]             s1_u2_ff, s1_u2_in, s1_j2_ff, s1_j2_in, s1_uj_ff, s1_uj_in;
   logic signed [COORD_BITS-1:0] s1_px_ff [4], s1_py_ff [4];

   always_comb begin
      logic [J_W-1:0] n;
      n         = J_W'(1) << tag_i.lg;
      s1_tag_in = tag_i;
      s1_j_in   = tag_i.index[J_W-1:0];
      s1_u_in   = n - s1_j_in;
      s1_u2_in  = SQ_W'(s1_u_in) * SQ_W'(s1_u_in);
      s1_j2_in  = SQ_W'(s1_j_in) * SQ_W'(s1_j_in);
      s1_uj_in  = SQ_W'(s1_u_in) * SQ_W'(s1_j_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
      end else begin
         s1_tag_ff <= s1_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_u_ff  <= s1_u_in;
      s1_j_ff  <= s1_j_in;
      s1_u2_ff <= s1_u2_in;
      s1_j2_ff <= s1_j2_in;
      s1_uj_ff <= s1_uj_in;
      s1_px_ff <= px_i;
      s1_py_ff <= py_i;
   end

   // stage 2: Bernstein weights
   cbs_tag_type                 s2_tag_ff;
   logic signed [WW-1:0]        s2_wp_ff [4], s2_wp_in [4];
   logic signed [WW-1:0]        s2_wt_ff [4], s2_wt_in [4];
   logic signed [COORD_BITS-1:0] s2_px_ff [4], s2_py_ff [4];

   always_comb begin
      logic [CU_W-1:0]      c_uuu, c_uuj, c_ujj, c_jjj;
      logic signed [WW-1:0] e_u2, e_j2, e_uj;
      c_uuu = CU_W'(s1_u2_ff) * CU_W'(s1_u_ff);
      c_uuj = CU_W'(s1_u2_ff) * CU_W'(s1_j_ff);
      c_ujj = CU_W'(s1_uj_ff) * CU_W'(s1_j_ff);
      c_jjj = CU_W'(s1_j2_ff) * CU_W'(s1_j_ff);
      e_u2  = signed'(WW'(s1_u2_ff));
      e_j2  = signed'(WW'(s1_j2_ff));
      e_uj  = signed'(WW'(s1_uj_ff));
      s2_wp_in[0] = signed'(WW'(c_uuu));
      s2_wp_in[1] = times3(signed'(WW'(c_uuj)));
      s2_wp_in[2] = times3(signed'(WW'(c_ujj)));
      s2_wp_in[3] = signed'(WW'(c_jjj));
      s2_wt_in[0] = -times3(e_u2);
      s2_wt_in[1] = times3(e_u2 - (e_uj <<< 1));
      s2_wt_in[2] = times3((e_uj <<< 1) - e_j2);
      s2_wt_in[3] = times3(e_j2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff <= '0;
      end else begin
         s2_tag_ff <= s1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_wp_ff <= s2_wp_in;
      s2_wt_ff <= s2_wt_in;
      s2_px_ff <= s1_px_ff;
      s2_py_ff <= s1_py_ff;
   end

   // stage 3: products
   cbs_tag_type          s3_tag_ff;
   logic signed [PW-1:0] s3_ppx_ff [4], s3_ppx_in [4], s3_ppy_ff [4], s3_ppy_in [4];
   logic signed [PW-1:0] s3_ptx_ff [4], s3_ptx_in [4], s3_pty_ff [4], s3_pty_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s3_ppx_in[k] = PW'(s2_px_ff[k]) * PW'(s2_wp_ff[k]);
         s3_ppy_in[k] = PW'(s2_py_ff[k]) * PW'(s2_wp_ff[k]);
         s3_ptx_in[k] = PW'(s2_px_ff[k]) * PW'(s2_wt_ff[k]);
         s3_pty_in[k] = PW'(s2_py_ff[k]) * PW'(s2_wt_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tag_ff <= '0;
      end else begin
         s3_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_ppx_ff <= s3_ppx_in;
      s3_ppy_ff <= s3_ppy_in;
      s3_ptx_ff <= s3_ptx_in;
      s3_pty_ff <= s3_pty_in;
   end

   // stage 4: numerators
   cbs_tag_type          s4_tag_ff;
   logic signed [SW-1:0] s4_nx_ff, s4_nx_in, s4_ny_ff, s4_ny_in;
   logic signed [SW-1:0] s4_dx_ff, s4_dx_in, s4_dy_ff, s4_dy_in;

   always_comb begin
      s4_nx_in = SW'(s3_ppx_ff[0]) + SW'(s3_ppx_ff[1]) + SW'(s3_ppx_ff[2]) + SW'(s3_ppx_ff[3]);
      s4_ny_in = SW'(s3_ppy_ff[0]) + SW'(s3_ppy_ff[1]) + SW'(s3_ppy_ff[2]) + SW'(s3_ppy_ff[3]);
      s4_dx_in = SW'(s3_ptx_ff[0]) + SW'(s3_ptx_ff[1]) + SW'(s3_ptx_ff[2]) + SW'(s3_ptx_ff[3]);
      s4_dy_in = SW'(s3_pty_ff[0]) + SW'(s3_pty_ff[1]) + SW'(s3_pty_ff[2]) + SW'(s3_pty_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_tag_ff <= '0;
      end else begin
         s4_tag_ff <= s3_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_nx_ff <= s4_nx_in;
      s4_ny_ff <= s4_ny_in;
      s4_dx_ff <= s4_dx_in;
      s4_dy_ff <= s4_dy_in;
   end

   // stage 5: divide by N^3 / N^2, rounding toward zero
   cbs_tag_type                  s5_tag_ff;
   logic signed [COORD_BITS-1:0] s5_px_ff, s5_px_in, s5_py_ff, s5_py_in;
   logic signed [TAN_W-1:0]      s5_tx_ff, s5_tx_in, s5_ty_ff, s5_ty_in;

   always_comb begin
      logic [K_W-1:0]       k3, k2;
      logic signed [SW-1:0] qx, qy, rx, ry;
      k2 = {1'b0, s4_tag_ff.lg, 1'b0};
      k3 = k2 + K_W'(s4_tag_ff.lg);
      qx = trunc_shift(s4_nx_ff, k3);
      qy = trunc_shift(s4_ny_ff, k3);
      rx = trunc_shift(s4_dx_ff, k2);
      ry = trunc_shift(s4_dy_ff, k2);
      s5_px_in = qx[COORD_BITS-1:0];
      s5_py_in = qy[COORD_BITS-1:0];
      s5_tx_in = rx[TAN_W-1:0];
      s5_ty_in = ry[TAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_tag_ff <= '0;
      end else begin
         s5_tag_ff <= s4_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_px_ff <= s5_px_in;
      s5_py_ff <= s5_py_in;
      s5_tx_ff <= s5_tx_in;
      s5_ty_ff <= s5_ty_in;
   end

   assign tag_o     = s5_tag_ff;
   assign point_x_o = s5_px_ff;
   assign point_y_o = s5_py_ff;
   assign tan_x_o   = s5_tx_ff;
   assign tan_y_o   = s5_ty_ff;

endmodule

FILE: src/cubic_bezier_sampler_core.sv
// channel    ports                   handshake
// request    start, busy, req_*      word taken at edge with start high, busy low
// response   rsp_*                   rsp_valid marks a word for one cycle, no back-pressure
// config     psel ... pready         write at psel & penable & pwrite, pready tied high
//
// One segment gives N+1 samples, N = 2**segments_log2 (capped at MAX_SEG_LOG2): the
// sample counter issues one sample per clock, and the next segment is taken on the
// cycle its last sample issues. Each sample is registered through datapath stages s1 to s5.
// Synchronous reset clears the sequencer and the pipeline valid bits; segments_log2 -> 5.
// The pipeline never stalls; results cannot be held off.
`include "cubic_bezier_sampler_core_assert.svh"

module cubic_bezier_sampler_core #(
   parameter int COORD_BITS   = cbs_pkg::COORD_BITS_DEFAULT,
   parameter int MAX_SEG_LOG2 = cbs_pkg::MAX_SEG_LOG2_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_BITS-1:0]         req_p0_x,
   input  logic signed [COORD_BITS-1:0]         req_p0_y,
   input  logic signed [COORD_BITS-1:0]         req_p1_x,
   input  logic signed [COORD_BITS-1:0]         req_p1_y,
   input  logic signed [COORD_BITS-1:0]         req_p2_x,
   input  logic signed [COORD_BITS-1:0]         req_p2_y,
   input  logic signed [COORD_BITS-1:0]         req_p3_x,
   input  logic signed [COORD_BITS-1:0]         req_p3_y,
   output logic                                 rsp_valid,
   output logic signed [COORD_BITS-1:0]         rsp_point_x,
   output logic signed [COORD_BITS-1:0]         rsp_point_y,
   output logic signed [cbs_pkg::TAN_W-1:0]     rsp_tangent_x,
   output logic signed [cbs_pkg::TAN_W-1:0]     rsp_tangent_y,
   output logic [cbs_pkg::IDX_W-1:0]            rsp_sample_index,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cbs_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [cbs_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [cbs_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import cbs_pkg::*;

   localparam int J_W = MAX_SEG_LOG2 + 1;

   // register file
   logic [LG_W-1:0] seg_log2_ff, seg_log2_in;
   logic            csr_write, csr_hit;

   assign csr_hit   = paddr[CSR_ADDR_W-1:CSR_IDX_LSB] == CSR_IDX_SEG_LOG2;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = csr_hit ? CSR_DATA_W'(seg_log2_ff) : '0;

   always_comb begin
      seg_log2_in = seg_log2_ff;
      if (csr_write && csr_hit) begin
         seg_log2_in = pwdata[LG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_log2_ff <= SEG_LOG2_RESET;
      end else begin
         seg_log2_ff <= seg_log2_in;
      end
   end

   // sample sequencer
   logic                          active_ff, active_in;
   logic [J_W-1:0]                j_ff, j_in;
   logic [LG_W-1:0]               lg_ff, lg_in;
   logic signed [COORD_BITS-1:0]  px_ff [4], px_in [4], py_ff [4], py_in [4];
   logic [LG_W-1:0]               lg_eff;
   logic [J_W-1:0]                n_now;
   logic                          last_now, take;

   assign lg_eff   = (seg_log2_ff > LG_W'(MAX_SEG_LOG2)) ? LG_W'(MAX_SEG_LOG2) : seg_log2_ff;
   assign n_now    = J_W'(1) << lg_ff;
   assign last_now = j_ff == n_now;
   assign busy     = active_ff && !last_now;
   assign take     = start && !busy;

   always_comb begin
      active_in = active_ff;
      j_in      = j_ff;
      lg_in     = lg_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      if (take) begin
         active_in = 1'b1;
         j_in      = '0;
         lg_in     = lg_eff;
         px_in     = '{req_p0_x, req_p1_x, req_p2_x, req_p3_x};
         py_in     = '{req_p0_y, req_p1_y, req_p2_y, req_p3_y};
      end else if (active_ff) begin
         if (last_now) begin
            active_in = 1'b0;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         j_ff      <= '0;
         lg_ff     <= '0;
      end else begin
         active_ff <= active_in;
         j_ff      <= j_in;
         lg_ff     <= lg_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
   end

   cbs_tag_type issue_tag, out_tag;

   always_comb begin
      issue_tag.valid = active_ff;
      issue_tag.last  = last_now;
      issue_tag.index = IDX_W'(j_ff);
      issue_tag.lg    = lg_ff;
   end

   cbs_datapath #(
      .COORD_BITS   (COORD_BITS),
      .MAX_SEG_LOG2 (MAX_SEG_LOG2)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .tag_i     (issue_tag),
      .px_i      (px_ff),
      .py_i      (py_ff),
      .tag_o     (out_tag),
      .point_x_o (rsp_point_x),
      .point_y_o (rsp_point_y),
      .tan_x_o   (rsp_tangent_x),
      .tan_y_o   (rsp_tangent_y)
   );

   assign rsp_valid        = out_tag.valid;
   assign rsp_last         = out_tag.last;
   assign rsp_sample_index = out_tag.index;

   `CBS_ASSERT_NEXT(a_take_loads, take, active_ff && j_ff == '0)
   `CBS_ASSERT_NEXT(a_count_step, active_ff && !last_now && !take,
                    active_ff && j_ff == $past(j_ff) + 1'b1)
   `CBS_ASSERT_NOW(a_count_bound, active_ff, j_ff <= n_now)
   `CBS_ASSERT_NEXT(a_csr_write, csr_write && csr_hit, seg_log2_ff == $past(pwdata[LG_W-1:0]))

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import cbs_pkg::*;

   localparam int CW = COORD_BITS_DEFAULT;
   localparam int MAX_LG = MAX_SEG_LOG2_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int WORDS_PER_PHASE = 55;

   typedef logic signed [CW-1:0]    coord_type;
   typedef logic signed [TAN_W-1:0] tan_type;
   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [LG_W-1:0]         lg_type;
   typedef logic [CSR_ADDR_W-1:0]   addr_type;

   typedef struct packed {
      coord_type p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
   } seg_type;

   typedef struct packed {
      coord_type pt_x, pt_y;
      tan_type   tn_x, tn_y;
      idx_type   index;
      logic      last;
   } sample_type;

   typedef struct packed {
      logic      wr;
      lg_type    lg;
      seg_type   seg;
      logic      typed;
      coord_type pt_x, pt_y;
   } row_type;

   localparam addr_type ADDR_SEG_LOG2 = addr_type'(CSR_IDX_SEG_LOG2) << CSR_IDX_LSB;
   localparam addr_type ADDR_UNMAPPED = addr_type'(1) << CSR_IDX_LSB;

   localparam coord_type CMIN = coord_type'(-(1 << (CW - 1)));
   localparam coord_type CMAX = coord_type'((1 << (CW - 1)) - 1);
   localparam coord_type CZ   = coord_type'(0);
   localparam coord_type CP1  = coord_type'(1);
   localparam coord_type CM1  = coord_type'(-1);

   // directed words; typed rows are flat curves: point equals the control point,
   // tangent is zero
   localparam row_type DIRECTED [15] = '{
      '{1'b0, lg_type'(0), '{CZ, CZ, CZ, CZ, CZ, CZ, CZ, CZ}, 1'b1, CZ, CZ},
      '{1'b0, lg_type'(0), '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, CMAX, CMAX},
      '{1'b0, lg_type'(0), '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, CMIN, CMIN},
      '{1'b0, lg_type'(0), '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}, 1'b1, CMAX, CMIN},
      '{1'b0, lg_type'(0), '{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN}, 1'b0, CZ, CZ},
      '{1'b0, lg_type'(0), '{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN}, 1'b0, CZ, CZ},
      '{1'b1, lg_type'(0), '{CMIN, CMAX, CMAX, CMIN, CZ, CZ, CM1, CP1}, 1'b0, CZ, CZ},
      '{1'b0, lg_type'(0), '{CM1, CP1, CM1, CP1, CM1, CP1, CM1, CP1}, 1'b1, CM1, CP1},
      '{1'b1, lg_type'(7), '{CZ, CZ, CMAX, CMAX, CMIN, CMIN, CZ, CZ}, 1'b0, CZ, CZ},
      '{1'b1, lg_type'(6), '{CP1, CM1, CP1, CM1, CP1, CM1, CP1, CM1}, 1'b1, CP1, CM1},
      '{1'b1, lg_type'(1), '{CMIN, CZ, CZ, CMIN, CZ, CMAX, CMAX, CZ}, 1'b0, CZ, CZ},
      '{1'b1, lg_type'(3), '{CM1, CM1, CZ, CZ, CZ, CZ, CZ, CZ}, 1'b0, CZ, CZ},
      '{1'b1, lg_type'(2), '{CZ, CZ, CM1, CP1, CP1, CM1, CZ, CZ}, 1'b0, CZ, CZ},
      '{1'b1, lg_type'(4), '{CZ, CMAX, CMIN, CZ, CMAX, CZ, CZ, CMIN}, 1'b0, CZ, CZ},
      '{1'b1, lg_type'(5), '{CM1, CM1, CM1, CM1, CP1, CP1, CP1, CP1}, 1'b0, CZ, CZ}
   };

   localparam lg_type PHASE_LG [9] = '{
      lg_type'(0), lg_type'(7), lg_type'(3), lg_type'(5), lg_type'(1),
      lg_type'(6), lg_type'(2), lg_type'(4), lg_type'(5)
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_p0_x = '0, req_p0_y = '0, req_p1_x = '0, req_p1_y = '0;
   coord_type req_p2_x = '0, req_p2_y = '0, req_p3_x = '0, req_p3_y = '0;
   logic rsp_valid;
   coord_type rsp_point_x, rsp_point_y;
   tan_type rsp_tangent_x, rsp_tangent_y;
   idx_type rsp_sample_index;
   logic rsp_last;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   addr_type paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   cubic_bezier_sampler_core dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   lg_type seg_log2_shadow = SEG_LOG2_RESET;
   sample_type samples_due[$];
   int faults = 0;
   int gap_pct = 0;
   int cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic longint pos_at(longint j, longint n, longint a, longint b,
                                     longint c, longint d);
      longint u;
      u = n - j;
      return (u*u*u*a + 3*u*u*j*b + 3*u*j*j*c + j*j*j*d) / (n*n*n);
   endfunction

   function automatic longint slope_at(longint j, longint n, longint a, longint b,
                                       longint c, longint d);
      longint u;
      u = n - j;
      return (-3*u*u*a + 3*(3*j*j - 4*j*n + n*n)*b + 3*(2*j*n - 3*j*j)*c + 3*j*j*d)
             / (n*n);
   endfunction

   function automatic sample_type bezier_sample(seg_type s, int j, int n);
      sample_type r;
      r.pt_x  = coord_type'(pos_at(j, n, s.p0x, s.p1x, s.p2x, s.p3x));
      r.pt_y  = coord_type'(pos_at(j, n, s.p0y, s.p1y, s.p2y, s.p3y));
      r.tn_x  = tan_type'(slope_at(j, n, s.p0x, s.p1x, s.p2x, s.p3x));
      r.tn_y  = tan_type'(slope_at(j, n, s.p0y, s.p1y, s.p2y, s.p3y));
      r.index = idx_type'(j);
      r.last  = (j == n);
      return r;
   endfunction

   function automatic coord_type draw_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: case ($urandom_range(0, 4))
               0: return CMIN;
               1: return CMAX;
               2: return CZ;
               3: return CM1;
               default: return CP1;
            endcase
         default: return coord_type'($urandom_range(0, 16)) - coord_type'(8);
      endcase
   endfunction

   function automatic seg_type draw_segment();
      seg_type s;
      int mode;
      int pick;
      pick = $urandom_range(0, 9);
      mode = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
      s = '{draw_coord(mode), draw_coord(mode), draw_coord(mode), draw_coord(mode),
            draw_coord(mode), draw_coord(mode), draw_coord(mode), draw_coord(mode)};
      if (pick == 9) begin
         s.p1x = s.p0x; s.p2x = s.p0x; s.p3x = s.p0x;
         s.p1y = s.p0y; s.p2y = s.p0y; s.p3y = s.p0y;
      end
      return s;
   endfunction

   task automatic offer_segment(input seg_type s, input logic typed, input coord_type tx,
                                input coord_type ty);
      sample_type e;
      int n;
      lg_type lg;
      if ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      start <= 1'b1;
      req_p0_x <= s.p0x; req_p0_y <= s.p0y;
      req_p1_x <= s.p1x; req_p1_y <= s.p1y;
      req_p2_x <= s.p2x; req_p2_y <= s.p2y;
      req_p3_x <= s.p3x; req_p3_y <= s.p3y;
      do @(posedge clock); while (busy);
      lg = (seg_log2_shadow > lg_type'(MAX_LG)) ? lg_type'(MAX_LG) : seg_log2_shadow;
      n = 1 << lg;
      for (int j = 0; j <= n; j++) begin
         e = bezier_sample(s, j, n);
         if (typed) begin
            e.pt_x = tx;
            e.pt_y = ty;
            e.tn_x = '0;
            e.tn_y = '0;
         end
         samples_due.push_back(e);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (samples_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write, then read back segments_log2
   task automatic csr_write(input addr_type addr, input logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if ((addr >> CSR_IDX_LSB) == addr_type'(CSR_IDX_SEG_LOG2))
         seg_log2_shadow = data[LG_W-1:0];
      penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_SEG_LOG2;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== CSR_DATA_W'(seg_log2_shadow)) begin
         faults++;
         $display("%0t segments_log2 read: expected %0d, got %0d", $time,
                  seg_log2_shadow, prdata);
      end
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic report(input string what, input logic signed [31:0] want,
                         input logic signed [31:0] got);
      if (want !== got) begin
         faults++;
         $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : sample_check
      sample_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (samples_due.size() == 0) begin
            faults++;
            $display("%0t unexpected word: index %0d", $time, rsp_sample_index);
         end else begin
            want = samples_due.pop_front();
            report("point_x", want.pt_x, rsp_point_x);
            report("point_y", want.pt_y, rsp_point_y);
            report("tangent_x", want.tn_x, rsp_tangent_x);
            report("tangent_y", want.tn_y, rsp_tangent_y);
            report("sample_index", {26'd0, want.index}, {26'd0, rsp_sample_index});
            report("last", {31'd0, want.last}, {31'd0, rsp_last});
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct = 15;
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].wr) begin
            settle();
            csr_write(ADDR_SEG_LOG2, CSR_DATA_W'(DIRECTED[i].lg));
         end
         offer_segment(DIRECTED[i].seg, DIRECTED[i].typed, DIRECTED[i].pt_x,
                       DIRECTED[i].pt_y);
      end

      for (int ph = 0; ph < 9; ph++) begin
         gap_pct = (ph < 3) ? 15 : (ph < 6) ? 56 : 0;
         settle();
         if (ph == 0)
            csr_write(ADDR_UNMAPPED, $urandom);
         csr_write(ADDR_SEG_LOG2, ($urandom & ~CSR_DATA_W'(7)) | CSR_DATA_W'(PHASE_LG[ph]));
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            if (ph == 4 && k == WORDS_PER_PHASE / 2)
               settle();
            offer_segment(draw_segment(), 1'b0, CZ, CZ);
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (faults == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: cubic_bezier_sampler_core.f
+incdir+src
src/cbs_pkg.sv
src/cbs_datapath.sv
src/cubic_bezier_sampler_core.sv
bench/tb.sv
